// ===== rtl/core/na_pkg.sv =====
package na_pkg;

   localparam int VALUE_BITS_DEFAULT = 32;
   localparam int REQ_VALUE_WIDTH = 32;
   localparam int MAX_DIGITS = 10;
   localparam int DIGIT_BITS = 4 * MAX_DIGITS;
   localparam int LEFT_WIDTH = $clog2(MAX_DIGITS + 1);

   localparam logic [1:0] CMD_DECIMAL = 2'd0;
   localparam logic [1:0] CMD_HEX     = 2'd1;
   localparam logic [1:0] CMD_PAD2    = 2'd2;

   localparam logic [6:0] CHAR_ZERO = 7'h30;
   localparam logic [6:0] CHAR_A    = 7'h41;
   localparam logic [3:0] DEC_BASE  = 4'hA;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic shift;
   } dp_cmd_type;

   typedef struct packed {
      logic hex;
      logic conv_done;
      logic top_zero;
      logic at_floor;
      logic at_last;
   } dp_status_type;

endpackage

// ===== rtl/core/number_to_ascii_digits.sv =====
// channel   ports                          handshake
// request   req_cmd, req_value             start high while busy low
// result    rsp_digit_char, rsp_last       rsp_valid, one digit per cycle
//
// decimal: VALUE_BITS (capped at 32) double-dabble steps, one per cycle, then
// leading zero digits are skipped one per cycle, the skip is left and the
// digits are sent one per cycle
// hex: the value is loaded as hex digits in place of the steps, then skip and send as above
// reset clears the sequencer only; the receiver cannot stall, so each digit
// is shown for exactly one cycle and busy stays high until the last one
module number_to_ascii_digits
   import na_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_cmd,
   input  logic [REQ_VALUE_WIDTH-1:0] req_value,
   output logic                       rsp_valid,
   output logic [6:0]                 rsp_digit_char,
   output logic                       rsp_last
);

   dp_cmd_type    cmd;
   dp_status_type status;

   na_control u_control (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   na_datapath #(
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock          (clock),
      .cmd            (cmd),
      .req_cmd        (req_cmd),
      .req_value      (req_value),
      .status         (status),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last)
   );

endmodule

// ===== rtl/core/na_datapath.sv =====
module na_datapath
   import na_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic                       clock,
   input  dp_cmd_type                 cmd,
   input  logic [1:0]                 req_cmd,
   input  logic [REQ_VALUE_WIDTH-1:0] req_value,
   output dp_status_type              status,
   output logic [6:0]                 rsp_digit_char,
   output logic                       rsp_last
);

   localparam int EFF_BITS = (VALUE_BITS < REQ_VALUE_WIDTH) ? VALUE_BITS : REQ_VALUE_WIDTH;
   localparam int STEP_WIDTH = $clog2(EFF_BITS);
   localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(EFF_BITS - 1);

   logic [EFF_BITS-1:0]   value_ff, value_in;
   logic [DIGIT_BITS-1:0] digits_ff, digits_in, adjusted;
   logic [STEP_WIDTH-1:0] step_ff, step_in;
   logic [LEFT_WIDTH-1:0] left_ff, left_in;
   logic                  hex_ff, hex_in;
   logic                  pad_ff, pad_in;
   logic [3:0]            top;

   // add three to every bcd digit of five or more
   always_comb begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (digits_ff[4*i +: 4] >= 4'd5) begin
            adjusted[4*i +: 4] = digits_ff[4*i +: 4] + 4'd3;
         end else begin
            adjusted[4*i +: 4] = digits_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      value_in  = value_ff;
      digits_in = digits_ff;
      step_in   = step_ff;
      left_in   = left_ff;
      hex_in    = hex_ff;
      pad_in    = pad_ff;
      if (cmd.load) begin
         value_in = req_value[EFF_BITS-1:0];
         step_in  = '0;
         left_in  = LEFT_WIDTH'(MAX_DIGITS);
         hex_in   = (req_cmd == CMD_HEX);
         pad_in   = (req_cmd == CMD_PAD2);
         if (req_cmd == CMD_HEX) begin
            digits_in = {{(DIGIT_BITS-EFF_BITS){1'b0}}, req_value[EFF_BITS-1:0]};
         end else begin
            digits_in = '0;
         end
      end else if (cmd.step) begin
         digits_in = {adjusted[DIGIT_BITS-2:0], value_ff[EFF_BITS-1]};
         value_in  = {value_ff[EFF_BITS-2:0], 1'b0};
         step_in   = step_ff + 1'b1;
      end else if (cmd.shift) begin
         digits_in = {digits_ff[DIGIT_BITS-5:0], 4'h0};
         left_in   = left_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      digits_ff <= digits_in;
      step_ff   <= step_in;
      left_ff   <= left_in;
      hex_ff    <= hex_in;
      pad_ff    <= pad_in;
   end

   assign top = digits_ff[DIGIT_BITS-1 -: 4];

   always_comb begin
      status.hex       = hex_ff;
      status.conv_done = (step_ff == LAST_STEP);
      status.top_zero  = (top == 4'h0);
      status.at_last   = (left_ff == LEFT_WIDTH'(1));
      status.at_floor  = pad_ff ? (left_ff == LEFT_WIDTH'(2)) : (left_ff == LEFT_WIDTH'(1));
   end

   always_comb begin
      if (top < DEC_BASE) begin
         rsp_digit_char = CHAR_ZERO + {3'b000, top};
      end else begin
         rsp_digit_char = CHAR_A + {3'b000, top - DEC_BASE};
      end
   end

   assign rsp_last = status.at_last;

endmodule

// ===== rtl/core/na_control.sv =====
module na_control
   import na_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type status,
   output dp_cmd_type    cmd,
   output logic          busy,
   output logic          rsp_valid
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            if (status.hex || status.conv_done) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (!status.top_zero || status.at_floor) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.at_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_CONVERT: begin
            cmd.step = !status.hex;
         end
         ST_SKIP: begin
            cmd.shift = status.top_zero && !status.at_floor;
         end
         ST_EMIT: begin
            cmd.shift = 1'b1;
            rsp_valid = 1'b1;
         end
         default: busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sim/number_to_ascii_digits_tb.sv =====
module number_to_ascii_digits_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import na_pkg::*;

   class digit_board;
      logic [6:0] char_q[$];
      logic       last_q[$];
      int         errors = 0;

      function logic [6:0] ascii_of(logic [3:0] d);
         if (d < DEC_BASE) begin
            return 7'(CHAR_ZERO + d);
         end
         return 7'(CHAR_A + (d - DEC_BASE));
      endfunction

      // digits of one request, most significant first
      function void note_request(logic [1:0] cmd, logic [31:0] value);
         logic [31:0] v;
         logic [31:0] base;
         logic [3:0]  digs[MAX_DIGITS];
         int          nd;
         int          i;
         v = value;
         base = (cmd == CMD_HEX) ? 32'd16 : 32'd10;
         nd = 0;
         do begin
            digs[nd] = 4'(v % base);
            v = v / base;
            nd++;
         end while (v != 0 && nd < MAX_DIGITS);
         if (cmd == CMD_PAD2 && nd == 1) begin
            char_q.push_back(CHAR_ZERO);
            last_q.push_back(1'b0);
         end
         for (i = nd - 1; i >= 0; i--) begin
            char_q.push_back(ascii_of(digs[i]));
            last_q.push_back(i == 0);
         end
      endfunction

      function void check_digit(logic [6:0] ch, logic fin);
         logic [6:0] exp_ch;
         logic       exp_last;
         if (char_q.size() == 0) begin
            $display("%0t: unexpected digit, expected none, actual char %h last %b",
                     $time, ch, fin);
            errors++;
         end else begin
            exp_ch = char_q.pop_front();
            exp_last = last_q.pop_front();
            if (ch !== exp_ch) begin
               $display("%0t: digit_char mismatch, expected %h actual %h", $time, exp_ch, ch);
               errors++;
            end
            if (fin !== exp_last) begin
               $display("%0t: last mismatch, expected %b actual %b", $time, exp_last, fin);
               errors++;
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_cmd = CMD_DECIMAL;
   logic [31:0] req_value = '0;
   logic        rsp_valid;
   logic [6:0]  rsp_digit_char;
   logic        rsp_last;

   digit_board board = new;

   number_to_ascii_digits u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         board.check_digit(rsp_digit_char, rsp_last);
      end
   end

   // returns at the edge that accepts the request
   task automatic send_request(logic [1:0] cmd, logic [31:0] value, bit idle_ok);
      if (idle_ok && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         req_cmd <= 2'($urandom);
         req_value <= $urandom;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      start <= 1'b1;
      req_cmd <= cmd;
      req_value <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_request(cmd, value);
   endtask

   function automatic logic [31:0] random_value();
      logic [31:0] p;
      int          k;
      p = 32'd1;
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return $urandom_range(0, 120);
         2: return $urandom >> $urandom_range(1, 31);
         3: begin
            k = $urandom_range(0, 9);
            repeat (k) p = p * 10;
            return p + $urandom_range(0, 2) - 1;
         end
         default: return (32'd1 << (4 * $urandom_range(0, 7))) - $urandom_range(0, 1);
      endcase
   endfunction

   initial begin
      logic [31:0] edge_vals[6];
      int          waited;
      int          m;
      int          j;
      int          n;
      edge_vals = '{32'd0, 32'd1, 32'd9, 32'd10, 32'hFFFF_FFFF, 32'd1_000_000_000};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      for (m = 0; m < 4; m++) begin
         for (j = 0; j < 6; j++) begin
            send_request(2'(m), edge_vals[j], 1'b1);
         end
      end
      for (n = 0; n < 480; n++) begin
         send_request(2'($urandom_range(0, 3)), random_value(), n < 420);
      end
      start <= 1'b0;
      waited = 0;
      while (board.char_q.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (60) @(posedge clock);
      if (board.char_q.size() != 0) begin
         $display("%0t: %0d digits expected, actual none", $time, board.char_q.size());
         board.errors++;
      end
      if (board.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/na_pkg.sv
rtl/core/na_datapath.sv
rtl/core/na_control.sv
rtl/core/number_to_ascii_digits.sv
sim/number_to_ascii_digits_tb.sv
